/* rtl/b64enc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder package
// Item types, queue entry layout and the sextet-to-ASCII mapping.
// ----------------------------------------------------------------------------
package b64enc_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3d;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       message_done;
	} out_item_t;

	typedef struct packed {
		logic       pad;
		logic [5:0] idx;
	} sym_t;

	typedef struct packed {
		logic [1:0]     last;
		logic           fin;
		sym_t [3:0]     syms;
	} job_t;

	function automatic logic [7:0] sym_ascii(input sym_t s);
		logic [7:0] v;
		logic [7:0] c;
		v = {2'b00, s.idx};
		if (s.pad) begin
			c = PAD_CHAR;
		end else if (v < 8'd26) begin
			c = v + 8'd65;
		end else if (v < 8'd52) begin
			c = v + 8'd71;
		end else if (v < 8'd62) begin
			c = v - 8'd4;
		end else if (v == 8'd62) begin
			c = 8'h2b;
		end else begin
			c = 8'h2f;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/b64enc_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder stream interface
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface b64enc_stream_if #(
	parameter type item_t = logic [7:0]
) ();

	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

/* rtl/base64_stream_encoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Padded base64 encoder: message bytes in, ASCII characters out.
// ----------------------------------------------------------------------------
// The bytes channel takes one message byte per transaction, with final_byte
// set on the last byte of a message. The chars channel gives one base64
// character or '=' per transaction; run_last marks the last character made by
// a byte and message_done the last character of the message.
// A byte is taken in any cycle in which the job queue has room. The first
// character of a byte passes through the queue and the character register
// before it is offered. The back end sends one character per cycle while
// the receiver is ready, so a byte yields one or two characters (three or
// four for a final byte that closes a short group); the character register
// is the limit. Reset clears the group position, the queue and the output
// valid flag; the block then starts at the beginning of a group. When the
// receiver stalls, the current character holds, the queue fills with up to
// QUEUE_DEPTH jobs and the bytes channel then drops ready.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	b64enc_stream_if.sink   bytes,
	b64enc_stream_if.source chars
);
	import b64enc_pkg::*;

	logic fq_valid;
	job_t fq_job;
	logic fq_ready;
	logic qb_valid;
	job_t qb_job;
	logic qb_ready;

	b64enc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.job_valid (fq_valid),
		.job       (fq_job),
		.job_ready (fq_ready)
	);

	b64enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_data  (fq_job),
		.push_ready (fq_ready),
		.pop_valid  (qb_valid),
		.pop_data   (qb_job),
		.pop_ready  (qb_ready)
	);

	b64enc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job       (qb_job),
		.job_ready (qb_ready),
		.chars     (chars)
	);

endmodule
`default_nettype wire

/* rtl/b64enc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts message bytes, tracks the group position and builds a character job.
// ----------------------------------------------------------------------------
module b64enc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	b64enc_stream_if.sink          bytes,
	output logic                   job_valid,
	output b64enc_pkg::job_t       job,
	input  wire logic              job_ready
);
	import b64enc_pkg::*;

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] phase_d;
	logic [3:0] carry_d;
	logic [7:0] b;
	logic       fin;

	assign b         = bytes.payload.data_byte;
	assign fin       = bytes.payload.final_byte;
	assign job_valid = bytes.valid;
	assign bytes.ready = job_ready;

	always_comb begin
		job     = '0;
		job.fin = fin;
		phase_d = phase_q;
		carry_d = carry_q;
		case (phase_q)
			2'd1: begin
				job.syms[0].idx = {carry_q[1:0], b[7:4]};
				job.last        = 2'd0;
				carry_d         = b[3:0];
				phase_d         = 2'd2;
				if (fin) begin
					job.syms[1].idx = {b[3:0], 2'b00};
					job.syms[2].pad = 1'b1;
					job.last        = 2'd2;
				end
			end
			2'd2: begin
				job.syms[0].idx = {carry_q, b[7:6]};
				job.syms[1].idx = b[5:0];
				job.last        = 2'd1;
				carry_d         = 4'd0;
				phase_d         = 2'd0;
			end
			default: begin
				job.syms[0].idx = b[7:2];
				job.last        = 2'd0;
				carry_d         = {2'b00, b[1:0]};
				phase_d         = 2'd1;
				if (fin) begin
					job.syms[1].idx = {b[1:0], 4'b0000};
					job.syms[2].pad = 1'b1;
					job.syms[3].pad = 1'b1;
					job.last        = 2'd3;
				end
			end
		endcase
		if (fin) begin
			phase_d = 2'd0;
			carry_d = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			carry_q <= 4'd0;
		end else if (bytes.valid && job_ready) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/b64enc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Small first-in first-out buffer of character jobs between front and back.
// ----------------------------------------------------------------------------
module b64enc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	input  wire b64enc_pkg::job_t  push_data,
	output logic                   push_ready,
	output logic                   pop_valid,
	output b64enc_pkg::job_t       pop_data,
	input  wire logic              pop_ready
);
	import b64enc_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/b64enc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Walks through the characters of each job and drives the output register.
// ----------------------------------------------------------------------------
module b64enc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	input  wire b64enc_pkg::job_t  job,
	output logic                   job_ready,
	b64enc_stream_if.source        chars
);
	import b64enc_pkg::*;

	logic [1:0] cnt_q;
	logic       valid_q;
	out_item_t  item_q;
	logic       load;
	logic       take;
	logic       at_last;

	assign load      = !valid_q || chars.ready;
	assign take      = job_valid && load;
	assign at_last   = (cnt_q == job.last);
	assign job_ready = take && at_last;

	assign chars.valid   = valid_q;
	assign chars.payload = item_q;

	always_ff @(posedge clk) begin
		if (take) begin
			item_q.out_char     <= sym_ascii(job.syms[cnt_q]);
			item_q.run_last     <= at_last;
			item_q.message_done <= at_last && job.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				cnt_q   <= at_last ? 2'd0 : cnt_q + 2'd1;
			end else if (chars.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
